// ----- rtl/mlfq_pkg.sv -----
// shared types and constants for the multilevel feedback queue scheduler
// no dependencies; imported by every module of the block
`default_nettype none

package mlfq_pkg;

   localparam int OP_W       = 3;
   localparam int PID_W      = 16;
   localparam int PRIO_W     = 5;
   localparam int TID_W      = 7;
   localparam int TICK_W     = 16;
   localparam int LEVEL_W    = 2;
   localparam int MAX_LEVELS = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef logic [LEVEL_W-1:0] level_type;

   localparam logic [TICK_W-1:0] QUANTUM_RESET [MAX_LEVELS] =
      '{16'd5, 16'd10, 16'd20, 16'd40};
   localparam logic [PRIO_W-1:0] BOOST_RESET = 5'd31;

   typedef enum logic [OP_W-1:0] {
      OP_CREATE = 3'd0,
      OP_TICK   = 3'd1,
      OP_YIELD  = 3'd2,
      OP_SLEEP  = 3'd3,
      OP_WAKE   = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NONE      = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      RS_READY    = 2'd0,
      RS_RUNNING  = 2'd1,
      RS_SLEEPING = 2'd2
   } run_state_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_QUANTUM0 = 3'd0,
      CSR_QUANTUM1 = 3'd1,
      CSR_QUANTUM2 = 3'd2,
      CSR_QUANTUM3 = 3'd3,
      CSR_BOOST    = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_EXEC = 2'd1,
      ST_DISP = 2'd2
   } fsm_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [PID_W-1:0]  owner_pid;
      logic [PRIO_W-1:0] thread_priority;
      logic [TID_W-1:0]  target_tid;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [TID_W-1:0]  created_tid;
      logic [TID_W-1:0]  running_tid;
      logic [PID_W-1:0]  running_pid;
      level_type         running_level;
      logic [TID_W-1:0]  thread_total;
      logic [TID_W-1:0]  ready_level0;
      logic [TID_W-1:0]  ready_level1;
      logic [TID_W-1:0]  ready_level2;
      logic [TID_W-1:0]  ready_level3;
   } rsp_type;

   // one thread table entry
   typedef struct packed {
      level_type         level;
      run_state_type     run_state;
      logic [PRIO_W-1:0] prio;
      logic [PID_W-1:0]  owner;
   } slot_type;

   // queue commands from the sequencer
   typedef struct packed {
      logic      enq;
      level_type enq_lvl;
      logic      disp;
      logic      head_load;
   } qcmd_type;

   // queue status back to the sequencer
   typedef struct packed {
      logic      disp_any;
      level_type disp_lvl;
      logic      link_we;
   } qstat_type;

endpackage

`default_nettype wire

// ----- rtl/mlfq_ram.sv -----
// single write port, single read port synchronous memory with registered read data
// a write to the address being read in the same cycle is forwarded to the read data
`default_nettype none

module mlfq_ram
   import mlfq_pkg::*;
#(
   parameter int WIDTH  = 25,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_q_ff;
   logic [WIDTH-1:0] byp_data_ff;
   logic             byp_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_q_ff     <= mem[rd_addr];
      byp_data_ff <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else begin
         byp_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : rd_q_ff;

endmodule

`default_nettype wire

// ----- rtl/mlfq_queues.sv -----
// per-level ready queue heads, tails and sizes; enqueue and dispatch selection
// uses mlfq_pkg; the next-links live in the link memory of the top level
`default_nettype none

module mlfq_queues
   import mlfq_pkg::*;
#(
   parameter int NUM_LEVELS = 4,
   parameter int SLOT_W     = 6,
   parameter int CNT_W      = 7
) (
   input  logic                               clock,
   input  logic                               reset,
   input  qcmd_type                           cmd,
   input  logic [SLOT_W-1:0]                  enq_slot,
   input  logic [SLOT_W-1:0]                  link_rdata,
   output qstat_type                          qst,
   output logic [SLOT_W-1:0]                  disp_slot,
   output logic [SLOT_W-1:0]                  link_waddr,
   output logic [NUM_LEVELS-1:0][CNT_W-1:0]   ready_cnt
);

   logic [SLOT_W-1:0] head_ff [NUM_LEVELS];
   logic [SLOT_W-1:0] head_in [NUM_LEVELS];
   logic [SLOT_W-1:0] tail_ff [NUM_LEVELS];
   logic [SLOT_W-1:0] tail_in [NUM_LEVELS];
   logic [CNT_W-1:0]  size_ff [NUM_LEVELS];
   logic [CNT_W-1:0]  size_in [NUM_LEVELS];
   level_type         disp_lvl_ff, disp_lvl_in;

   logic [NUM_LEVELS-1:0] hit;
   logic [CNT_W-1:0]      size_enq [NUM_LEVELS];
   logic [SLOT_W-1:0]     head_enq [NUM_LEVELS];
   logic                  found;
   level_type             lvl;

   always_comb begin
      found      = 1'b0;
      lvl        = '0;
      disp_slot  = '0;
      link_waddr = '0;
      qst        = '0;
      // enqueue goes first, dispatch sees the queues after it
      for (int l = 0; l < NUM_LEVELS; l++) begin
         hit[l]      = cmd.enq && (cmd.enq_lvl == level_type'(l));
         size_enq[l] = size_ff[l] + CNT_W'(hit[l]);
         head_enq[l] = (hit[l] && size_ff[l] == '0) ? enq_slot : head_ff[l];
         if (hit[l] && size_ff[l] != '0) begin
            qst.link_we = 1'b1;
            link_waddr  = tail_ff[l];
         end
      end
      for (int l = 0; l < NUM_LEVELS; l++) begin
         if (!found && size_enq[l] != '0) begin
            found     = 1'b1;
            lvl       = level_type'(l);
            disp_slot = head_enq[l];
         end
      end
      qst.disp_any = found;
      qst.disp_lvl = lvl;
      for (int l = 0; l < NUM_LEVELS; l++) begin
         size_in[l] = size_enq[l]
                    - CNT_W'(cmd.disp && found && (lvl == level_type'(l)));
         tail_in[l] = hit[l] ? enq_slot : tail_ff[l];
         // new head arrives from the link memory in the cycle after dispatch
         head_in[l] = (cmd.head_load && disp_lvl_ff == level_type'(l)) ?
                      link_rdata : head_enq[l];
      end
      disp_lvl_in = (cmd.disp && found) ? lvl : disp_lvl_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < NUM_LEVELS; l++) begin
            head_ff[l] <= '0;
            tail_ff[l] <= '0;
            size_ff[l] <= '0;
         end
         disp_lvl_ff <= '0;
      end else begin
         for (int l = 0; l < NUM_LEVELS; l++) begin
            head_ff[l] <= head_in[l];
            tail_ff[l] <= tail_in[l];
            size_ff[l] <= size_in[l];
         end
         disp_lvl_ff <= disp_lvl_in;
      end
   end

   always_comb begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
         ready_cnt[l] = size_ff[l];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/mlfq_thread_scheduler_unit.sv -----
// Multilevel feedback queue thread scheduler. Pulse start with an event on
// req_data while busy is low; the response appears on rsp_data for exactly one
// cycle with rsp_strobe high and must be taken then, as the block cannot be
// held off. Create, wake, a tick that does not expire, a sleep or yield that
// finds nothing to run, and unknown event codes go from execute back to idle
// with the strobe; busy drops with the strobe, so a new start is taken in that
// cycle. Events that dispatch a thread (expiring tick, yield, sleep) also pass
// the dispatch state, which takes the thread table and link memory reads for
// the new head of the chosen queue. Thread table entries are written on create
// and are never cleared, so there is no clearing pass after reset. Quantum and
// boost registers may be written on the csr_ port while the block is idle.
`default_nettype none

module mlfq_thread_scheduler_unit
   import mlfq_pkg::*;
#(
   parameter int MAX_THREADS = 64,
   parameter int NUM_LEVELS  = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_strobe,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int SLOT_W    = $clog2(MAX_THREADS);
   localparam int CNT_W     = $clog2(MAX_THREADS + 1);
   localparam int CMP_W     = CNT_W + TID_W;
   localparam int SLOT_BITS = $bits(slot_type);
   localparam level_type LAST_LVL = level_type'(NUM_LEVELS - 1);

   fsm_type           state_ff, state_in;
   req_type           req_ff, req_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              run_valid_ff, run_valid_in;
   logic [SLOT_W-1:0] run_slot_ff, run_slot_in;
   level_type         run_level_ff, run_level_in;
   logic [PRIO_W-1:0] run_prio_ff, run_prio_in;
   logic [PID_W-1:0]  run_owner_ff, run_owner_in;
   logic [TICK_W-1:0] ticks_ff, ticks_in;
   status_type        status_ff, status_in;
   logic [TID_W-1:0]  created_ff, created_in;
   logic              strobe_ff, strobe_in;
   logic [TICK_W-1:0] quantum_ff [MAX_LEVELS];
   logic [PRIO_W-1:0] boost_ff;

   // event decode
   logic              enq_en;
   logic [SLOT_W-1:0] enq_slot;
   level_type         enq_base;
   level_type         enq_lvl;
   logic [PRIO_W-1:0] enq_prio;
   logic [PID_W-1:0]  enq_owner;
   logic              sleep_en;
   logic              disp_en;
   logic              create_en;
   status_type        status_pre;
   logic [TICK_W-1:0] ticks_dec;

   // thread table and link memory
   logic                 tab_we;
   logic [SLOT_W-1:0]    tab_waddr;
   slot_type             tab_wdata;
   logic [SLOT_W-1:0]    tab_raddr;
   logic [SLOT_BITS-1:0] tab_rdata;
   slot_type             tab_rd;
   logic [SLOT_W-1:0]    link_rdata;
   logic [SLOT_W-1:0]    link_waddr;

   qcmd_type                        qcmd;
   qstat_type                       qst;
   logic [SLOT_W-1:0]               disp_slot;
   logic [NUM_LEVELS-1:0][CNT_W-1:0] ready_cnt;

   logic [CMP_W-1:0]  tid_req_wide;
   logic [CMP_W-1:0]  tid_wide;
   logic [SLOT_W-1:0] wake_addr_req;
   logic [SLOT_W-1:0] wake_addr;
   logic              tid_ok;
   logic [CMP_W-1:0]  created_wide;
   logic [CMP_W-1:0]  run_tid_wide;
   logic [CMP_W-1:0]  total_wide;
   logic [CMP_W-1:0]  ready_wide [MAX_LEVELS];
   logic [TID_W-1:0]  ready_out [MAX_LEVELS];

   assign tab_rd = slot_type'(tab_rdata);

   mlfq_ram #(
      .WIDTH  (SLOT_BITS),
      .DEPTH  (MAX_THREADS),
      .ADDR_W (SLOT_W)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (tab_we),
      .wr_addr (tab_waddr),
      .wr_data (tab_wdata),
      .rd_addr (tab_raddr),
      .rd_data (tab_rdata)
   );

   mlfq_ram #(
      .WIDTH  (SLOT_W),
      .DEPTH  (MAX_THREADS),
      .ADDR_W (SLOT_W)
   ) u_link (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (qst.link_we),
      .wr_addr (link_waddr),
      .wr_data (enq_slot),
      .rd_addr (tab_raddr),
      .rd_data (link_rdata)
   );

   mlfq_queues #(
      .NUM_LEVELS (NUM_LEVELS),
      .SLOT_W     (SLOT_W),
      .CNT_W      (CNT_W)
   ) u_queues (
      .clock      (clock),
      .reset      (reset),
      .cmd        (qcmd),
      .enq_slot   (enq_slot),
      .link_rdata (link_rdata),
      .qst        (qst),
      .disp_slot  (disp_slot),
      .link_waddr (link_waddr),
      .ready_cnt  (ready_cnt)
   );

   // thread ids run from one, table slots from zero
   assign tid_req_wide  = CMP_W'(req_data.target_tid) - CMP_W'(1);
   assign wake_addr_req = tid_req_wide[SLOT_W-1:0];
   assign tid_wide      = CMP_W'(req_ff.target_tid) - CMP_W'(1);
   assign wake_addr     = tid_wide[SLOT_W-1:0];
   assign tid_ok        = (req_ff.target_tid != '0) &&
                          (CMP_W'(req_ff.target_tid) <= CMP_W'(count_ff));
   assign created_wide  = CMP_W'(count_ff) + CMP_W'(1);
   assign ticks_dec     = ticks_ff - TICK_W'(1);

   always_comb begin
      enq_en     = 1'b0;
      enq_slot   = '0;
      enq_base   = '0;
      enq_prio   = '0;
      enq_owner  = '0;
      sleep_en   = 1'b0;
      disp_en    = 1'b0;
      create_en  = 1'b0;
      status_pre = STAT_OK;
      if (state_ff == ST_EXEC) begin
         unique case (req_ff.op)
            OP_CREATE: begin
               if (count_ff >= CNT_W'(MAX_THREADS)) begin
                  status_pre = STAT_FULL;
               end else begin
                  create_en = 1'b1;
                  enq_en    = 1'b1;
                  enq_slot  = count_ff[SLOT_W-1:0];
                  enq_prio  = req_ff.thread_priority;
                  enq_owner = req_ff.owner_pid;
               end
            end
            OP_TICK: begin
               if (!run_valid_ff) begin
                  status_pre = STAT_NONE;
               end else if (ticks_dec == '0) begin
                  // quantum spent: demote one level (the last level stays) and requeue
                  enq_en    = 1'b1;
                  enq_slot  = run_slot_ff;
                  enq_base  = (run_level_ff == LAST_LVL) ? run_level_ff :
                              run_level_ff + level_type'(1);
                  enq_prio  = run_prio_ff;
                  enq_owner = run_owner_ff;
                  disp_en   = 1'b1;
               end
            end
            OP_YIELD: begin
               if (run_valid_ff) begin
                  enq_en    = 1'b1;
                  enq_slot  = run_slot_ff;
                  enq_base  = run_level_ff;
                  enq_prio  = run_prio_ff;
                  enq_owner = run_owner_ff;
               end
               disp_en = 1'b1;
            end
            OP_SLEEP: begin
               if (!run_valid_ff) begin
                  status_pre = STAT_NONE;
               end else begin
                  sleep_en = 1'b1;
                  disp_en  = 1'b1;
               end
            end
            OP_WAKE: begin
               // table entry was read in the cycle the request was taken
               if (tid_ok && tab_rd.run_state == RS_SLEEPING) begin
                  enq_en    = 1'b1;
                  enq_slot  = wake_addr;
                  enq_base  = tab_rd.level;
                  enq_prio  = tab_rd.prio;
                  enq_owner = tab_rd.owner;
               end else begin
                  status_pre = STAT_NOT_FOUND;
               end
            end
            default: begin
            end
         endcase
      end
      enq_lvl = (enq_prio >= boost_ff) ? level_type'(0) : enq_base;
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      run_valid_in = run_valid_ff;
      run_slot_in  = run_slot_ff;
      run_level_in = run_level_ff;
      run_prio_in  = run_prio_ff;
      run_owner_in = run_owner_ff;
      ticks_in     = ticks_ff;
      status_in    = status_ff;
      created_in   = created_ff;
      strobe_in    = 1'b0;
      qcmd         = '0;
      tab_we       = 1'b0;
      tab_waddr    = '0;
      tab_wdata    = '0;
      tab_raddr    = disp_slot;
      unique case (state_ff)
         ST_IDLE: begin
            tab_raddr = wake_addr_req;
            if (start) begin
               req_in   = req_data;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            qcmd.enq     = enq_en;
            qcmd.enq_lvl = enq_lvl;
            qcmd.disp    = disp_en;
            status_in    = status_pre;
            created_in   = create_en ? created_wide[TID_W-1:0] : '0;
            if (create_en) begin
               count_in = count_ff + CNT_W'(1);
            end
            if (req_ff.op == OP_TICK && run_valid_ff) begin
               ticks_in = ticks_dec;
            end
            if (enq_en) begin
               tab_we              = 1'b1;
               tab_waddr           = enq_slot;
               tab_wdata.level     = enq_lvl;
               tab_wdata.run_state = RS_READY;
               tab_wdata.prio      = enq_prio;
               tab_wdata.owner     = enq_owner;
            end else if (sleep_en) begin
               tab_we              = 1'b1;
               tab_waddr           = run_slot_ff;
               tab_wdata.level     = run_level_ff;
               tab_wdata.run_state = RS_SLEEPING;
               tab_wdata.prio      = run_prio_ff;
               tab_wdata.owner     = run_owner_ff;
            end
            state_in  = ST_IDLE;
            strobe_in = 1'b1;
            if (disp_en) begin
               if (qst.disp_any) begin
                  run_valid_in = 1'b1;
                  run_slot_in  = disp_slot;
                  run_level_in = qst.disp_lvl;
                  ticks_in     = quantum_ff[qst.disp_lvl];
                  state_in     = ST_DISP;
                  strobe_in    = 1'b0;
               end else begin
                  run_valid_in = 1'b0;
                  if (req_ff.op == OP_YIELD) begin
                     status_in = STAT_NONE;
                  end
               end
            end
         end
         ST_DISP: begin
            // head entry and its link are back from the memories
            tab_we              = 1'b1;
            tab_waddr           = run_slot_ff;
            tab_wdata.level     = tab_rd.level;
            tab_wdata.run_state = RS_RUNNING;
            tab_wdata.prio      = tab_rd.prio;
            tab_wdata.owner     = tab_rd.owner;
            run_prio_in         = tab_rd.prio;
            run_owner_in        = tab_rd.owner;
            qcmd.head_load      = 1'b1;
            strobe_in           = 1'b1;
            state_in            = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         run_valid_ff <= 1'b0;
         run_slot_ff  <= '0;
         ticks_ff     <= '0;
         status_ff    <= STAT_OK;
         created_ff   <= '0;
         strobe_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         run_valid_ff <= run_valid_in;
         run_slot_ff  <= run_slot_in;
         ticks_ff     <= ticks_in;
         status_ff    <= status_in;
         created_ff   <= created_in;
         strobe_ff    <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      run_level_ff <= run_level_in;
      run_prio_ff  <= run_prio_in;
      run_owner_ff <= run_owner_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < MAX_LEVELS; l++) begin
            quantum_ff[l] <= QUANTUM_RESET[l];
         end
         boost_ff <= BOOST_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_QUANTUM0: quantum_ff[0] <= csr_wdata;
            CSR_QUANTUM1: quantum_ff[1] <= csr_wdata;
            CSR_QUANTUM2: quantum_ff[2] <= csr_wdata;
            CSR_QUANTUM3: quantum_ff[3] <= csr_wdata;
            CSR_BOOST:    boost_ff      <= csr_wdata[PRIO_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // response view of the scheduler state
   for (genvar g = 0; g < MAX_LEVELS; g++) begin : g_ready
      if (g < NUM_LEVELS) begin : g_used
         assign ready_wide[g] = CMP_W'(ready_cnt[g]);
      end else begin : g_unused
         assign ready_wide[g] = '0;
      end
      assign ready_out[g] = ready_wide[g][TID_W-1:0];
   end

   assign run_tid_wide = CMP_W'(run_slot_ff) + CMP_W'(1);
   assign total_wide   = CMP_W'(count_ff);

   always_comb begin
      rsp_data.status        = status_ff;
      rsp_data.created_tid   = created_ff;
      rsp_data.running_tid   = run_valid_ff ? run_tid_wide[TID_W-1:0] : '0;
      rsp_data.running_pid   = run_valid_ff ? run_owner_ff : '0;
      rsp_data.running_level = run_valid_ff ? run_level_ff : '0;
      rsp_data.thread_total  = total_wide[TID_W-1:0];
      rsp_data.ready_level0  = ready_out[0];
      rsp_data.ready_level1  = ready_out[1];
      rsp_data.ready_level2  = ready_out[2];
      rsp_data.ready_level3  = ready_out[3];
   end

   assign rsp_strobe = strobe_ff;
   assign busy       = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

// ----- rtl/mlfq_checker.sv -----
// port-level checks for the scheduler, attached to the top level by bind
// uses mlfq_pkg and mlfq_thread_scheduler_unit
`default_nettype none

module mlfq_checker
   import mlfq_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input rsp_type rsp_data,
   input logic    rsp_strobe
);

   // one response per request, never two back to back
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held for two cycles");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request taken but block not busy");

   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      (!busy && $past(busy) && !$past(reset)) |-> rsp_strobe)
      else $error("block went idle without a response");

   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.running_tid == '0) |->
      (rsp_data.running_pid == '0 && rsp_data.running_level == '0))
      else $error("running fields set with no thread running");

   a_created: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.created_tid != '0) |->
      (rsp_data.status == STAT_OK && rsp_data.created_tid == rsp_data.thread_total))
      else $error("created id does not match thread count");

endmodule

bind mlfq_thread_scheduler_unit mlfq_checker u_mlfq_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_data   (rsp_data),
   .rsp_strobe (rsp_strobe)
);

`default_nettype wire
